>>> sv/bbd_pkg.sv
// Shared constants and types for the Bayer BGGR demosaic block.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none
package bbd_pkg;
	localparam int MAX_WIDTH   = 2048;
	localparam int MAX_HEIGHT  = 2048;
	localparam int STORE_DEPTH = MAX_WIDTH / 2;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);
	localparam int PAIR_W      = STORE_AW + 1;
	localparam int PIX_W       = 8;
	localparam int COORD_W     = 11;
	localparam int ROW_W       = 11;
	localparam int CFG_W       = 12;
	localparam int CFG_IDX_W   = 1;
	localparam int ENTRY_W     = 2 * PIX_W;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
	localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_idx_t;

	// beat of a quad on the output
	typedef enum logic [1:0] {
		BEAT_TOP_LEFT  = 2'd0,
		BEAT_TOP_RIGHT = 2'd1,
		BEAT_BOT_LEFT  = 2'd2,
		BEAT_BOT_RIGHT = 2'd3
	} beat_t;

	// one complete quad waiting to be sent as four pixels
	typedef struct packed {
		logic [PIX_W-1:0]   red;
		logic [PIX_W-1:0]   g_lo;
		logic [PIX_W-1:0]   g_up;
		logic [PIX_W-1:0]   blue;
		logic [COORD_W-1:0] col;
		logic [ROW_W-1:0]   top;
		logic [ROW_W-1:0]   bot;
		logic               frame_end;
	} quad_t;
endpackage
`default_nettype wire

>>> sv/bbd_in_if.sv
// Input channel: one pair of raw Bayer samples per item.
// Depends on bbd_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface bbd_in_if;
	logic                      valid;
	logic                      ready;
	logic [bbd_pkg::PIX_W-1:0] first_sample;
	logic [bbd_pkg::PIX_W-1:0] second_sample;

	modport source (output valid, output first_sample, output second_sample, input ready);
	modport sink (input valid, input first_sample, input second_sample, output ready);
endinterface
`default_nettype wire

>>> sv/bbd_out_if.sv
// Output channel: one RGB pixel with its frame position per item.
// Depends on bbd_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface bbd_out_if;
	logic                        valid;
	logic                        ready;
	logic [bbd_pkg::PIX_W-1:0]   red;
	logic [bbd_pkg::PIX_W-1:0]   green;
	logic [bbd_pkg::PIX_W-1:0]   blue;
	logic [bbd_pkg::COORD_W-1:0] pixel_column;
	logic [bbd_pkg::ROW_W-1:0]   pixel_row;
	logic                        last_in_run;
	logic                        frame_done;

	modport source (output valid, output red, output green, output blue,
		output pixel_column, output pixel_row, output last_in_run, output frame_done,
		input ready);
	modport sink (input valid, input red, input green, input blue,
		input pixel_column, input pixel_row, input last_in_run, input frame_done,
		output ready);
endinterface
`default_nettype wire

>>> sv/bbd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bbd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

>>> sv/bayer_bggr_demosaic_core.sv
// Top level of the Bayer BGGR nearest-neighbor demosaic.
// Depends on bbd_pkg, bbd_in_if, bbd_out_if and bbd_ram.
//
// channel   direction  carries
// pix_in    in         first_sample, second_sample (one raw pair)
// pix_out   out        red, green, blue, pixel_column, pixel_row, last_in_run, frame_done
// cfg       in         cfg_we, cfg_index, cfg_data (image_width, image_height)
//
// An even-row item is written to the line store at acceptance and gives no output.
// An odd-row item reads the line store, waits in s1 for the read data, then moves to
// the output stage, which sends its quad as four pixels, one pixel per cycle while
// pix_out.ready is high; the single output port bounds the rate of odd items.
// Inputs are taken every cycle while s1 is free or moving on; output stalls back up
// through s1. Reset clears counters, valid bits and the configuration to 640 x 480.
`timescale 1ns / 1ps
`default_nettype none
module bayer_bggr_demosaic_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	bbd_in_if.sink                           pix_in,
	bbd_out_if.source                        pix_out,
	input  wire logic                        cfg_we,
	input  wire logic [bbd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bbd_pkg::CFG_W-1:0]   cfg_data
);
	import bbd_pkg::*;

	logic [CFG_W-1:0]    width_q;
	logic [CFG_W-1:0]    height_q;
	logic [STORE_AW-1:0] pair_col_q;
	logic [ROW_W-1:0]    row_q;

	logic [PAIR_W-1:0]   pairs;
	logic [CFG_W-2:0]    half_width;
	logic [CFG_W-1:0]    rows;
	logic [CFG_W-1:0]    height_even;
	logic                row_end;
	logic                frame_end;
	logic                odd_row;
	logic                in_acc;
	logic                s1_advance;
	logic                s2_done;

	logic                valid_s1;
	logic [PIX_W-1:0]    red_s1;
	logic [PIX_W-1:0]    g_lo_s1;
	logic [COORD_W-1:0]  col_s1;
	logic [ROW_W-1:0]    top_s1;
	logic [ROW_W-1:0]    bot_s1;
	logic                frame_end_s1;

	logic                valid_s2;
	quad_t               quad_s2;
	beat_t               beat_q;

	logic                store_we;
	logic                store_re;
	logic [ENTRY_W-1:0]  store_wdata;
	logic [ENTRY_W-1:0]  store_rdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pairs per row, clamped to 1..STORE_DEPTH
	assign half_width = width_q[CFG_W-1:1];
	always_comb begin
		if (half_width == '0) begin
			pairs = PAIR_W'(1);
		end else if ({1'b0, half_width} > CFG_W'(STORE_DEPTH)) begin
			pairs = PAIR_W'(STORE_DEPTH);
		end else begin
			pairs = PAIR_W'(half_width);
		end
	end

	// rows per frame, even, clamped to 2..MAX_HEIGHT
	assign height_even = {height_q[CFG_W-1:1], 1'b0};
	always_comb begin
		if (height_even < CFG_W'(2)) begin
			rows = CFG_W'(2);
		end else if (height_even > CFG_W'(MAX_HEIGHT)) begin
			rows = CFG_W'(MAX_HEIGHT);
		end else begin
			rows = height_even;
		end
	end

	assign odd_row   = row_q[0];
	assign row_end   = ({1'b0, pair_col_q} + PAIR_W'(1)) >= pairs;
	assign frame_end = row_end && (({1'b0, row_q} + CFG_W'(1)) >= rows);

	// handshake control
	assign s2_done       = valid_s2 && pix_out.ready && (beat_q == BEAT_BOT_RIGHT);
	assign s1_advance    = valid_s1 && (!valid_s2 || s2_done);
	assign pix_in.ready  = !valid_s1 || s1_advance;
	assign in_acc        = pix_in.valid && pix_in.ready;

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_col_q <= '0;
			row_q      <= '0;
		end else if (in_acc) begin
			if (row_end) begin
				pair_col_q <= '0;
				if (odd_row && frame_end) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end else begin
				pair_col_q <= pair_col_q + STORE_AW'(1);
			end
		end
	end

	// line store: even rows write, odd rows read
	assign store_we    = in_acc && !odd_row;
	assign store_re    = in_acc && odd_row;
	assign store_wdata = {pix_in.second_sample, pix_in.first_sample};

	bbd_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (pair_col_q),
		.wdata (store_wdata),
		.re    (store_re),
		.raddr (pair_col_q),
		.rdata (store_rdata)
	);

	// s1: odd-row item waits here for the store read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_in.ready) begin
			valid_s1 <= store_re;
		end
	end

	always_ff @(posedge clk) begin
		if (store_re) begin
			g_lo_s1      <= pix_in.first_sample;
			red_s1       <= pix_in.second_sample;
			col_s1       <= {pair_col_q, 1'b0};
			top_s1       <= row_q - ROW_W'(1);
			bot_s1       <= row_q;
			frame_end_s1 <= frame_end;
		end
	end

	// s2: output register, four beats per quad
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			beat_q   <= BEAT_TOP_LEFT;
		end else if (s1_advance) begin
			valid_s2 <= 1'b1;
			beat_q   <= BEAT_TOP_LEFT;
		end else if (s2_done) begin
			valid_s2 <= 1'b0;
			beat_q   <= BEAT_TOP_LEFT;
		end else if (valid_s2 && pix_out.ready) begin
			beat_q <= beat_t'(beat_q + 2'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_advance) begin
			quad_s2.red       <= red_s1;
			quad_s2.g_lo      <= g_lo_s1;
			quad_s2.g_up      <= store_rdata[ENTRY_W-1:PIX_W];
			quad_s2.blue      <= store_rdata[PIX_W-1:0];
			quad_s2.col       <= col_s1;
			quad_s2.top       <= top_s1;
			quad_s2.bot       <= bot_s1;
			quad_s2.frame_end <= frame_end_s1;
		end
	end

	// pixel select by beat
	assign pix_out.valid = valid_s2;
	assign pix_out.red   = quad_s2.red;
	assign pix_out.blue  = quad_s2.blue;

	always_comb begin
		pix_out.green        = quad_s2.g_lo;
		pix_out.pixel_column = quad_s2.col;
		pix_out.pixel_row    = quad_s2.top;
		pix_out.last_in_run  = 1'b0;
		pix_out.frame_done   = 1'b0;
		case (beat_q)
			BEAT_TOP_LEFT: begin
			end
			BEAT_TOP_RIGHT: begin
				pix_out.green        = quad_s2.g_up;
				pix_out.pixel_column = quad_s2.col | COORD_W'(1);
			end
			BEAT_BOT_LEFT: begin
				pix_out.pixel_row = quad_s2.bot;
			end
			BEAT_BOT_RIGHT: begin
				pix_out.green        = quad_s2.g_up;
				pix_out.pixel_column = quad_s2.col | COORD_W'(1);
				pix_out.pixel_row    = quad_s2.bot;
				pix_out.last_in_run  = 1'b1;
				pix_out.frame_done   = quad_s2.frame_end;
			end
			default: begin
			end
		endcase
	end

	// beats of a quad step one at a time
	a_beat_step: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && pix_out.ready && (beat_q != BEAT_BOT_RIGHT)
		|=> valid_s2 && (beat_q == beat_t'($past(beat_q) + 2'd1)))
		else $error("quad beat skipped or lost");

	// frame end only on the last pixel of a quad
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		pix_out.valid && pix_out.frame_done |-> pix_out.last_in_run)
		else $error("frame_done without last_in_run");

	// a waiting quad in s1 keeps its position while blocked
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_advance |=> valid_s1 && $stable(col_s1) && $stable(bot_s1))
		else $error("s1 item changed while blocked");

	// even rows never enter the output path
	a_even_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !odd_row |=> !valid_s1)
		else $error("even-row item entered s1");

	// right-hand pixels sit on odd columns
	a_right_odd: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && ((beat_q == BEAT_TOP_RIGHT) || (beat_q == BEAT_BOT_RIGHT))
		|-> pix_out.pixel_column[0])
		else $error("right pixel on even column");
endmodule
`default_nettype wire

>>> verif/bayer_bggr_demosaic_core_tb.sv
// Self-checking testbench for bayer_bggr_demosaic_core: a short stimulus table, resizes and
// random frames of varied geometry. Each pixel is compared with a built-in demosaic predictor.
// Depends on bbd_pkg, bbd_in_if, bbd_out_if and the block itself.
`timescale 1ns / 1ps
module bayer_bggr_demosaic_core_tb;
	import bbd_pkg::*;

	localparam int SETTLE_CYCLES = 12;
	localparam int STALL_LIMIT   = 5000;
	localparam int PRINT_CAP     = 60;
	localparam int TABLE_ROWS    = 16;

	typedef logic [PIX_W-1:0] sample_t;

	// colors of a quad typed in by hand, used only when known is set
	typedef struct packed {
		logic    known;
		sample_t red;
		sample_t g_left;
		sample_t g_right;
		sample_t blue;
	} typed_quad_t;

	typedef struct packed {
		sample_t     left_sample;
		sample_t     right_sample;
		typed_quad_t typed;
	} stim_row_t;

	typedef struct packed {
		sample_t            red;
		sample_t            green;
		sample_t            blue;
		logic [COORD_W-1:0] col;
		logic [ROW_W-1:0]   row;
		logic               last;
		logic               done;
	} pixel_t;

	localparam typed_quad_t NO_TYPED = '0;

	// two 4x4 frames: even rows hold B,G and odd rows G,R
	localparam logic [$bits(stim_row_t)-1:0] STIM_TABLE [TABLE_ROWS] = '{
		{8'h00, 8'hFF, 1'b0, 32'h0},
		{8'hFF, 8'h00, 1'b0, 32'h0},
		{8'h00, 8'hFF, 1'b1, 8'hFF, 8'h00, 8'hFF, 8'h00},
		{8'hFF, 8'h00, 1'b1, 8'h00, 8'hFF, 8'h00, 8'hFF},
		{8'h55, 8'hAA, 1'b0, 32'h0},
		{8'hAA, 8'h55, 1'b0, 32'h0},
		{8'hAA, 8'h55, 1'b1, 8'h55, 8'hAA, 8'hAA, 8'h55},
		{8'h55, 8'hAA, 1'b1, 8'hAA, 8'h55, 8'h55, 8'hAA},
		{8'hFF, 8'hFF, 1'b0, 32'h0},
		{8'h00, 8'h00, 1'b0, 32'h0},
		{8'hFF, 8'hFF, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
		{8'h00, 8'h00, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00},
		{8'h01, 8'h80, 1'b0, 32'h0},
		{8'h80, 8'h01, 1'b0, 32'h0},
		{8'h7F, 8'hFE, 1'b1, 8'hFE, 8'h7F, 8'h80, 8'h01},
		{8'hFE, 8'h7F, 1'b1, 8'h7F, 8'hFE, 8'h01, 8'h80}
	};

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	reg_idx_t         cfg_index;
	logic [CFG_W-1:0] cfg_data;

	bbd_in_if  in_ch();
	bbd_out_if out_ch();

	bayer_bggr_demosaic_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_in    (in_ch),
		.pix_out   (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor state: geometry, raster position and the stored even row
	logic [CFG_W-1:0]   geo_width;
	logic [CFG_W-1:0]   geo_height;
	int unsigned        cur_pair;
	int unsigned        cur_row;
	logic [ENTRY_W-1:0] line_store [STORE_DEPTH];

	pixel_t pending_pixels [$];

	int unsigned error_count;
	int unsigned pairs_sent;
	int unsigned pixels_checked;
	int unsigned frames_seen;
	int unsigned settings_applied;
	int unsigned idle_cycles;
	int unsigned src_idle_pct;
	int unsigned snk_idle_pct;

	// clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		if (error_count < PRINT_CAP) begin
			$display("ERROR %0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
		end
		error_count++;
	endtask

	// one accepted pair: store it on an even row, emit a quad on an odd row
	function automatic void predict_quad(input sample_t left_s, input sample_t right_s,
			input typed_quad_t typed);
		int unsigned        pairs;
		int unsigned        rows;
		int unsigned        slot;
		logic               row_end;
		logic               frame_end;
		logic [ENTRY_W-1:0] entry;
		sample_t            red;
		sample_t            g_lo;
		sample_t            g_up;
		sample_t            blue;
		logic [COORD_W-1:0] col;
		logic [ROW_W-1:0]   top;
		logic [ROW_W-1:0]   bot;
		pairs = geo_width >> 1;
		if (pairs < 1) pairs = 1;
		if (pairs > STORE_DEPTH) pairs = STORE_DEPTH;
		rows = geo_height & ~32'd1;
		if (rows < 2) rows = 2;
		if (rows > MAX_HEIGHT) rows = MAX_HEIGHT & ~1;
		slot = (cur_pair < STORE_DEPTH) ? cur_pair : STORE_DEPTH - 1;
		row_end = (cur_pair + 1) >= pairs;

		if (cur_row[0] == 1'b0) begin
			line_store[slot] = {right_s, left_s};
			if (row_end) begin
				cur_pair = 0;
				cur_row = cur_row + 1;
			end else begin
				cur_pair = cur_pair + 1;
			end
		end else begin
			entry = line_store[slot];
			blue = entry[PIX_W-1:0];
			g_up = entry[ENTRY_W-1:PIX_W];
			g_lo = left_s;
			red = right_s;
			if (typed.known) begin
				red = typed.red;
				g_lo = typed.g_left;
				g_up = typed.g_right;
				blue = typed.blue;
			end
			col = COORD_W'(cur_pair * 2);
			top = ROW_W'(cur_row - 1);
			bot = ROW_W'(cur_row);
			frame_end = row_end && ((cur_row + 1) >= rows);
			pending_pixels.push_back({red, g_lo, blue, col, top, 1'b0, 1'b0});
			pending_pixels.push_back({red, g_up, blue, COORD_W'(col + 1), top, 1'b0, 1'b0});
			pending_pixels.push_back({red, g_lo, blue, col, bot, 1'b0, 1'b0});
			pending_pixels.push_back({red, g_up, blue, COORD_W'(col + 1), bot, 1'b1, frame_end});
			if (row_end) begin
				cur_pair = 0;
				cur_row = frame_end ? 0 : cur_row + 1;
			end else begin
				cur_pair = cur_pair + 1;
			end
		end
	endfunction

	// offer one pair, with a random hold-off first, and predict it once taken
	task automatic send_pair(input sample_t left_s, input sample_t right_s,
			input typed_quad_t typed);
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.first_sample <= left_s;
		in_ch.second_sample <= right_s;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		predict_quad(left_s, right_s, typed);
		pairs_sent++;
	endtask

	// random pairs until the raster is back at the start of a frame
	task automatic send_frame();
		do begin
			send_pair(sample_t'($urandom), sample_t'($urandom), NO_TYPED);
		end while (cur_row != 0 || cur_pair != 0);
	endtask

	// even-row items give no pixel, so let the pipeline settle after the queue drains
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic change_geometry(input logic [CFG_W-1:0] width,
			input logic [CFG_W-1:0] height);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data <= width;
		@(posedge clk);
		geo_width = width;
		cfg_index <= REG_IMAGE_HEIGHT;
		cfg_data <= height;
		@(posedge clk);
		geo_height = height;
		cfg_we <= 1'b0;
		settings_applied++;
	endtask

	// whole frames of small random geometry, sometimes keeping the last one
	task automatic run_random_frames(input int unsigned count);
		int unsigned start_count;
		start_count = pairs_sent;
		while (pairs_sent - start_count < count) begin
			if ($urandom_range(1) == 0) begin
				change_geometry(CFG_W'($urandom_range(0, 17)), CFG_W'($urandom_range(0, 9)));
			end
			send_frame();
		end
	endtask

	// pixel receiver: random stalls, compare against the oldest expectation
	always @(posedge clk) begin : pixel_check
		pixel_t got;
		pixel_t want;
		if (out_ch.valid && out_ch.ready) begin
			got = {out_ch.red, out_ch.green, out_ch.blue, out_ch.pixel_column,
				out_ch.pixel_row, out_ch.last_in_run, out_ch.frame_done};
			if (pending_pixels.size() == 0) begin
				report_mismatch("pixel with nothing pending, row/col", {got.row, got.col}, 0);
			end else begin
				want = pending_pixels.pop_front();
				if (got.red !== want.red) report_mismatch("red", got.red, want.red);
				if (got.green !== want.green) report_mismatch("green", got.green, want.green);
				if (got.blue !== want.blue) report_mismatch("blue", got.blue, want.blue);
				if (got.col !== want.col) report_mismatch("pixel_column", got.col, want.col);
				if (got.row !== want.row) report_mismatch("pixel_row", got.row, want.row);
				if (got.last !== want.last) report_mismatch("last_in_run", got.last, want.last);
				if (got.done !== want.done) report_mismatch("frame_done", got.done, want.done);
				if (want.done) frames_seen++;
				pixels_checked++;
			end
		end
		out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// watchdog on cycles in which no item moves on either channel
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Watchdog: no item moved for %0d cycles, %0d pixels still pending",
				idle_cycles, pending_pixels.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		stim_row_t stim;
		in_ch.valid = 1'b0;
		in_ch.first_sample = '0;
		in_ch.second_sample = '0;
		out_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_data = '0;
		geo_width = WIDTH_RESET;
		geo_height = HEIGHT_RESET;
		cur_pair = 0;
		cur_row = 0;
		error_count = 0;
		pairs_sent = 0;
		pixels_checked = 0;
		frames_seen = 0;
		settings_applied = 0;
		idle_cycles = 0;
		src_idle_pct = 25;
		snk_idle_pct = 68;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry: a few pairs into the first 640-wide even row
		repeat (8) send_pair(sample_t'($urandom), sample_t'($urandom), NO_TYPED);
		// shrink the width mid-row: the pair column past the new end wraps
		change_geometry(12'd4, 12'd4);
		send_frame();

		// stimulus table: two 4x4 frames of extreme and alternating samples
		for (int i = 0; i < TABLE_ROWS; i++) begin
			stim = STIM_TABLE[i];
			send_pair(stim.left_sample, stim.right_sample, stim.typed);
		end
		run_random_frames(60);

		// sender mostly idle, receiver mostly ready
		src_idle_pct = 68;
		snk_idle_pct = 25;
		change_geometry(12'd2, 12'd2);
		send_frame();
		send_frame();
		// shrink the height mid-frame: the row count past the new end wraps at row end
		change_geometry(12'd8, 12'd12);
		while (!(cur_row == 5 && cur_pair == 1)) begin
			send_pair(sample_t'($urandom), sample_t'($urandom), NO_TYPED);
		end
		change_geometry(12'd7, 12'd4);
		send_frame();
		run_random_frames(60);

		// no idling: geometry below the minimum, odd sizes, then random frames
		src_idle_pct = 0;
		snk_idle_pct = 0;
		change_geometry(12'd1, 12'd0);
		send_frame();
		change_geometry(12'd13, 12'd5);
		send_frame();
		run_random_frames(70);

		wait_idle();
		$display("Sent %0d pairs, checked %0d pixels over %0d frames, %0d geometry settings",
			pairs_sent, pixels_checked, frames_seen, settings_applied);
		$display("Covered reset geometry, clamped and odd sizes, and mid-frame resizes");
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
